### rtl/grid_metric_stencil_defines.svh
// ----------------------------------------------------------------------------
// grid_metric_stencil_defines
// assertion macros used by the grid metric stencil controller
// ----------------------------------------------------------------------------
`ifndef GRID_METRIC_STENCIL_DEFINES_SVH
`define GRID_METRIC_STENCIL_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define GMS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gms assertion failed");
// antecedent implies consequent in the next cycle
`define GMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gms assertion failed");
`else
`define GMS_ASSERT_SAME(lbl, ante, cons)
`define GMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/gms_pkg.sv
// ----------------------------------------------------------------------------
// gms_pkg
// constants, types and command structs of the grid metric stencil
// ----------------------------------------------------------------------------
package gms_pkg;
    localparam int GRID_ROWS   = 256;
    localparam int GRID_COLS   = 256;
    localparam int GHOST_CELLS = 2;
    localparam int CNT_W       = 8;
    localparam int COORD_W     = 32;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int AREA_W      = PROD_W + 1;
    localparam int AREA_SHIFT  = 17;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = ROOT_W + 2;
    localparam int MUL_OPS     = 10;
    localparam int K_W         = 4;
    localparam int STEP_W      = 5;

    localparam int MV_LO_I = ((GHOST_CELLS - 1) > 1 ? (GHOST_CELLS - 1) : 1) + 1;
    localparam int SV_LO_I = (GHOST_CELLS > 1 ? GHOST_CELLS : 1) + 1;
    localparam logic [CNT_W:0] MV_R_LO = (CNT_W+1)'(MV_LO_I);
    localparam logic [CNT_W:0] MV_R_HI = (CNT_W+1)'(GRID_ROWS - GHOST_CELLS + 1);
    localparam logic [CNT_W:0] MV_C_HI = (CNT_W+1)'(GRID_COLS - GHOST_CELLS + 1);
    localparam logic [CNT_W:0] SV_R_LO = (CNT_W+1)'(SV_LO_I);
    localparam logic [CNT_W:0] SV_R_HI = (CNT_W+1)'(GRID_ROWS - GHOST_CELLS);
    localparam logic [CNT_W:0] SV_C_HI = (CNT_W+1)'(GRID_COLS - GHOST_CELLS);

    localparam logic [K_W-1:0] K_AREA_P = 4'd0;
    localparam logic [K_W-1:0] K_AREA_Q = 4'd1;
    localparam logic [K_W-1:0] K_FIRST_DY = 4'd3;
    localparam logic [K_W-1:0] K_LAST = 4'(MUL_OPS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = 5'(ROOT_W - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_SHIFT, S_MUL, S_DRAIN, S_SQ_INIT, S_SQ, S_FINISH
    } t_state;

    typedef struct packed {
        logic           take;
        logic           rd;
        logic           shift;
        logic           mul_en;
        logic [K_W-1:0] mul_k;
        logic           sq_init;
        logic           sq_step;
        logic           load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } t_dp_sts;
endpackage

### rtl/gms_if.sv
// ----------------------------------------------------------------------------
// gms_if
// request channels of the grid metric stencil
// ----------------------------------------------------------------------------
interface gms_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic               first_point;
    modport source (output valid, x_coord, y_coord, first_point, input ready);
    modport sink   (input valid, x_coord, y_coord, first_point, output ready);
endinterface

interface gms_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         center_row;
    logic [7:0]         center_col;
    logic               metric_valid;
    logic signed [31:0] xi_x;
    logic signed [31:0] xi_y;
    logic signed [31:0] eta_x;
    logic signed [31:0] eta_y;
    logic               area_valid;
    logic signed [31:0] cell_area;
    logic               spacing_valid;
    logic [31:0]        min_spacing;
    modport source (output valid, center_row, center_col, metric_valid, xi_x, xi_y,
                    eta_x, eta_y, area_valid, cell_area, spacing_valid, min_spacing,
                    input ready);
    modport sink   (input valid, center_row, center_col, metric_valid, xi_x, xi_y,
                    eta_x, eta_y, area_valid, cell_area, spacing_valid, min_spacing,
                    output ready);
endinterface

### rtl/gms_ctrl.sv
// ----------------------------------------------------------------------------
// gms_ctrl
// sequencer: line read, window shift, shared multiplier, square root steps
// ----------------------------------------------------------------------------
`include "grid_metric_stencil_defines.svh"
module gms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gms_pkg::t_dp_sts  i_sts,
    output gms_pkg::t_ctl_cmd o_cmd
);
    import gms_pkg::*;

    t_state           r_state, n_state;
    logic [K_W-1:0]   r_k, n_k;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_step  = r_step;
        case (r_state)
            S_IDLE:    if (i_sts.in_valid) n_state = S_READ;
            S_READ:    n_state = S_SHIFT;
            S_SHIFT: begin
                n_state = S_MUL;
                n_k     = '0;
            end
            S_MUL: begin
                if (r_k == K_LAST) n_state = S_DRAIN;
                else n_k = r_k + 1'b1;
            end
            S_DRAIN:   n_state = S_SQ_INIT;
            S_SQ_INIT: begin
                n_state = S_SQ;
                n_step  = '0;
            end
            S_SQ: begin
                if (r_step == STEP_LAST) n_state = S_FINISH;
                else n_step = r_step + 1'b1;
            end
            S_FINISH:  if (!i_sts.out_busy) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_k    = r_k;
        o_cmd.take     = (r_state == S_IDLE);
        o_cmd.rd       = (r_state == S_READ);
        o_cmd.shift    = (r_state == S_SHIFT);
        o_cmd.mul_en   = (r_state == S_MUL);
        o_cmd.sq_init  = (r_state == S_SQ_INIT);
        o_cmd.sq_step  = (r_state == S_SQ);
        o_cmd.load_out = (r_state == S_FINISH) && !i_sts.out_busy;
    end

    `GMS_ASSERT_NEXT(a_take_reads, o_cmd.take && i_sts.in_valid, o_cmd.rd)
    `GMS_ASSERT_SAME(a_load_free, o_cmd.load_out, !i_sts.out_busy)
    `GMS_ASSERT_SAME(a_k_range, o_cmd.mul_en, o_cmd.mul_k <= K_LAST)
    `GMS_ASSERT_NEXT(a_last_mul_drains, o_cmd.mul_en && o_cmd.mul_k == K_LAST,
        !o_cmd.mul_en && !o_cmd.take)
endmodule

### rtl/gms_dp.sv
// ----------------------------------------------------------------------------
// gms_dp
// datapath: counters, line stores, 3x3 window, multiplier, root, output reg
// ----------------------------------------------------------------------------
module gms_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gms_pkg::t_ctl_cmd i_cmd,
    output gms_pkg::t_dp_sts  o_sts,
    gms_in_if.sink            i_in,
    gms_out_if.source         o_out
);
    import gms_pkg::*;

    logic [CNT_W-1:0] r_rowc, r_colc, r_row, r_col, w_cur_r, w_cur_c;
    logic signed [COORD_W-1:0] r_xin, r_yin;
    logic [2*COORD_W-1:0] m_bank0 [GRID_COLS];
    logic [2*COORD_W-1:0] m_bank1 [GRID_COLS];
    logic [2*COORD_W-1:0] r_rd0, r_rd1;
    logic signed [COORD_W-1:0] r_xw [9];
    logic signed [COORD_W-1:0] r_yw [9];
    logic signed [DIFF_W-1:0] w_a, w_b;
    logic signed [PROD_W-1:0] w_prod, r_prod;
    logic [K_W-1:0] r_pk;
    logic           r_pv;
    logic signed [AREA_W-1:0] r_area, w_sh;
    logic [PROD_W-1:0] r_sq, r_min, w_sum;
    logic [2*ROOT_W-1:0] r_v;
    logic [REM_W-1:0]    r_rem;
    logic [REM_W+1:0]    w_rem_t, w_trial;
    logic [ROOT_W-1:0]   r_root;
    logic                r_sat;
    logic                r_ov;
    logic                w_mv, w_sv, w_av, w_fit;
    logic [COORD_W-1:0]  w_area_out;
    logic [DIFF_W-1:0]   w_xi_x, w_xi_y, w_eta_x, w_eta_y;
    logic                w_take;

    function automatic logic signed [DIFF_W-1:0] sub33(logic signed [COORD_W-1:0] a,
                                                       logic signed [COORD_W-1:0] b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    assign w_take       = i_cmd.take && i_in.valid;
    assign i_in.ready   = i_cmd.take;
    assign o_sts.in_valid = i_in.valid;
    assign o_sts.out_busy = r_ov && !o_out.ready;

    assign w_cur_r = i_in.first_point ? '0 : r_rowc;
    assign w_cur_c = i_in.first_point ? '0 : r_colc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rowc <= '0;
            r_colc <= '0;
        end else if (w_take) begin
            if (w_cur_c == CNT_W'(GRID_COLS - 1)) begin
                r_colc <= '0;
                r_rowc <= (w_cur_r == CNT_W'(GRID_ROWS - 1)) ? '0 : w_cur_r + 1'b1;
            end else begin
                r_colc <= w_cur_c + 1'b1;
                r_rowc <= w_cur_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_row <= w_cur_r;
            r_col <= w_cur_c;
            r_xin <= i_in.x_coord;
            r_yin <= i_in.y_coord;
        end
    end

    // line store of the previous row
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd0 <= m_bank0[r_col];
        if (i_cmd.shift) m_bank0[r_col] <= {r_xin, r_yin};
    end

    // line store of the row before that
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd1 <= m_bank1[r_col];
        if (i_cmd.shift) m_bank1[r_col] <= r_rd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_xw[i] <= '0;
                r_yw[i] <= '0;
            end
        end else if (i_cmd.shift) begin
            for (int k = 0; k < 3; k++) begin
                r_xw[3*k]   <= r_xw[3*k+1];
                r_xw[3*k+1] <= r_xw[3*k+2];
                r_yw[3*k]   <= r_yw[3*k+1];
                r_yw[3*k+1] <= r_yw[3*k+2];
            end
            r_xw[2] <= r_rd1[2*COORD_W-1:COORD_W];
            r_yw[2] <= r_rd1[COORD_W-1:0];
            r_xw[5] <= r_rd0[2*COORD_W-1:COORD_W];
            r_yw[5] <= r_rd0[COORD_W-1:0];
            r_xw[8] <= r_xin;
            r_yw[8] <= r_yin;
        end
    end

    // operands of the shared multiplier: two area products, then eight squares
    always_comb begin
        case (i_cmd.mul_k)
            4'd0: begin w_a = sub33(r_xw[8], r_xw[4]); w_b = sub33(r_yw[5], r_yw[7]); end
            4'd1: begin w_a = sub33(r_yw[8], r_yw[4]); w_b = sub33(r_xw[5], r_xw[7]); end
            4'd2: begin w_a = sub33(r_xw[7], r_xw[4]); w_b = w_a; end
            4'd3: begin w_a = sub33(r_yw[7], r_yw[4]); w_b = w_a; end
            4'd4: begin w_a = sub33(r_xw[5], r_xw[4]); w_b = w_a; end
            4'd5: begin w_a = sub33(r_yw[5], r_yw[4]); w_b = w_a; end
            4'd6: begin w_a = sub33(r_xw[1], r_xw[4]); w_b = w_a; end
            4'd7: begin w_a = sub33(r_yw[1], r_yw[4]); w_b = w_a; end
            4'd8: begin w_a = sub33(r_xw[3], r_xw[4]); w_b = w_a; end
            4'd9: begin w_a = sub33(r_yw[3], r_yw[4]); w_b = w_a; end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_sum  = r_sq + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
            r_pk   <= i_cmd.mul_k;
        end
        if (r_pv) begin
            if (r_pk == K_AREA_P) r_area <= AREA_W'(r_prod);
            else if (r_pk == K_AREA_Q) r_area <= r_area - AREA_W'(r_prod);
            else if (!r_pk[0]) r_sq <= r_prod;
            else if (r_pk == K_FIRST_DY || w_sum < r_min) r_min <= w_sum;
        end
    end

    // restoring square root, one result bit per step
    assign w_rem_t = {r_rem, r_v[2*ROOT_W-1:2*ROOT_W-2]};
    assign w_trial = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_v    <= r_min[2*ROOT_W-1:0];
            r_sat  <= |r_min[PROD_W-1:2*ROOT_W];
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_v <= {r_v[2*ROOT_W-3:0], 2'b00};
            if (w_rem_t >= w_trial) begin
                r_rem  <= REM_W'(w_rem_t - w_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(w_rem_t);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign w_sh  = r_area >>> AREA_SHIFT;
    assign w_fit = (&w_sh[AREA_W-1:COORD_W-1]) || !(|w_sh[AREA_W-1:COORD_W-1]);
    assign w_area_out = w_fit ? w_sh[COORD_W-1:0]
                      : (r_area[AREA_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign w_av = (r_row != '0) && (r_col != '0);
    assign w_mv = ({1'b0, r_row} >= MV_R_LO) && ({1'b0, r_row} <= MV_R_HI)
               && ({1'b0, r_col} >= MV_R_LO) && ({1'b0, r_col} <= MV_C_HI);
    assign w_sv = ({1'b0, r_row} >= SV_R_LO) && ({1'b0, r_row} <= SV_R_HI)
               && ({1'b0, r_col} >= SV_R_LO) && ({1'b0, r_col} <= SV_C_HI);

    // floor halving is an arithmetic shift of the 33-bit difference
    assign w_xi_x  = sub33(r_yw[5], r_yw[3]) >>> 1;
    assign w_xi_y  = sub33(r_xw[3], r_xw[5]) >>> 1;
    assign w_eta_x = sub33(r_yw[1], r_yw[7]) >>> 1;
    assign w_eta_y = sub33(r_xw[7], r_xw[1]) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out.center_row    <= r_row - 1'b1;
            o_out.center_col    <= r_col - 1'b1;
            o_out.metric_valid  <= w_mv;
            o_out.xi_x          <= w_mv ? w_xi_x[COORD_W-1:0] : '0;
            o_out.xi_y          <= w_mv ? w_xi_y[COORD_W-1:0] : '0;
            o_out.eta_x         <= w_mv ? w_eta_x[COORD_W-1:0] : '0;
            o_out.eta_y         <= w_mv ? w_eta_y[COORD_W-1:0] : '0;
            o_out.area_valid    <= w_av;
            o_out.cell_area     <= w_av ? w_area_out : '0;
            o_out.spacing_valid <= w_sv;
            o_out.min_spacing   <= !w_sv ? '0 : (r_sat ? 32'hFFFF_FFFF : r_root);
        end
    end

    assign o_out.valid = r_ov;
endmodule

### rtl/grid_metric_stencil.sv
// ----------------------------------------------------------------------------
// grid_metric_stencil
// streamed curvilinear grid metrics from a 3x3 coordinate window
// ----------------------------------------------------------------------------
// grid points enter on i_in in raster order, rows outer, columns inner;
// first_point restarts the row and column counters at point (0,0).
// each request yields one result on o_out for the window centred one row and
// one column back: four half-difference metrics, the vertex cell area and the
// root of the least squared neighbour distance, each with its valid flag.
// one request is worked at a time: a new request is taken only when the last
// one is through, after the ten products through the shared multiplier and
// the 32 square root steps have run and the result is loaded.
// the result sits in an output register; while the receiver stalls the
// block finishes the next request and waits with it in its final state.
// after reset the counters and window are zero; the line stores hold
// nothing meaningful until a row has passed, which only reaches results whose
// valid flags are low.
// ----------------------------------------------------------------------------
module grid_metric_stencil (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gms_in_if.sink    i_in,
    gms_out_if.source o_out
);
    import gms_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;

    gms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    gms_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

### tb/sv/grid_metric_stencil_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_metric_stencil_tb
// self-checking bench for the streamed grid metric stencil
// ----------------------------------------------------------------------------
// grid points are pushed in raster order through the request channel; an
// in-bench predictor keeps its own line stores, 3x3 window and counters and
// queues the expected result of every accepted point. results are checked
// field by field in order. both channels idle at random, with a quiet stretch.
// ----------------------------------------------------------------------------
module grid_metric_stencil_tb;
    import gms_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        logic [7:0]         center_row;
        logic [7:0]         center_col;
        logic               metric_valid;
        logic signed [31:0] xi_x;
        logic signed [31:0] xi_y;
        logic signed [31:0] eta_x;
        logic signed [31:0] eta_y;
        logic               area_valid;
        logic signed [31:0] cell_area;
        logic               spacing_valid;
        logic [31:0]        min_spacing;
    } t_metric_res;

    class metric_scoreboard;
        logic signed [31:0] x_rows [2][GRID_COLS];
        logic signed [31:0] y_rows [2][GRID_COLS];
        logic signed [31:0] xw [9];
        logic signed [31:0] yw [9];
        int row_cnt, col_cnt;
        t_metric_res pending_q [$];
        int n_in, n_out, errors, n_metric, n_area, n_spacing;

        function new();
            foreach (x_rows[i, j]) begin
                x_rows[i][j] = '0;
                y_rows[i][j] = '0;
            end
            foreach (xw[i]) begin
                xw[i] = '0;
                yw[i] = '0;
            end
        endfunction

        function automatic logic [31:0] half_of(logic signed [32:0] d);
            logic signed [32:0] h;
            h = d >>> 1;
            return h[31:0];
        endfunction

        function automatic logic [31:0] root64(logic [63:0] v);
            logic [63:0] r, b;
            r = '0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r[31:0];
        endfunction

        function automatic logic [65:0] sq_dist(int a, int b);
            logic signed [32:0] dx, dy;
            logic signed [65:0] sx, sy;
            dx = xw[a] - xw[b];
            dy = yw[a] - yw[b];
            sx = dx * dx;
            sy = dy * dy;
            return sx + sy;
        endfunction

        // predict the result of one accepted grid point
        function void note_point(logic signed [31:0] xn, logic signed [31:0] yn, logic fp);
            t_metric_res e;
            int r, c, cr, cc;
            logic signed [32:0] d1, d2, d3, d4;
            logic signed [65:0] p, q;
            logic signed [66:0] dd, sh;
            logic [65:0] m, t;
            if (fp) begin
                row_cnt = 0;
                col_cnt = 0;
            end
            r = row_cnt;
            c = col_cnt;
            for (int k = 0; k < 3; k++) begin
                xw[k*3] = xw[k*3+1]; xw[k*3+1] = xw[k*3+2];
                yw[k*3] = yw[k*3+1]; yw[k*3+1] = yw[k*3+2];
            end
            xw[2] = x_rows[1][c]; yw[2] = y_rows[1][c];
            xw[5] = x_rows[0][c]; yw[5] = y_rows[0][c];
            xw[8] = xn; yw[8] = yn;
            x_rows[1][c] = x_rows[0][c]; y_rows[1][c] = y_rows[0][c];
            x_rows[0][c] = xn; y_rows[0][c] = yn;

            cr = r - 1;
            cc = c - 1;
            e.center_row = 8'(cr);
            e.center_col = 8'(cc);
            e.area_valid = (r >= 1 && c >= 1);
            e.metric_valid = e.area_valid && cr >= 1 && cc >= 1 &&
                cr >= GHOST_CELLS - 1 && cr <= GRID_ROWS - GHOST_CELLS &&
                cc >= GHOST_CELLS - 1 && cc <= GRID_COLS - GHOST_CELLS;
            e.spacing_valid = e.area_valid && cr >= 1 && cc >= 1 &&
                cr >= GHOST_CELLS && cr <= GRID_ROWS - GHOST_CELLS - 1 &&
                cc >= GHOST_CELLS && cc <= GRID_COLS - GHOST_CELLS - 1;

            e.xi_x = '0; e.xi_y = '0; e.eta_x = '0; e.eta_y = '0;
            if (e.metric_valid) begin
                e.xi_x  = half_of(33'(yw[5]) - 33'(yw[3]));
                e.xi_y  = half_of(33'(xw[3]) - 33'(xw[5]));
                e.eta_x = half_of(33'(yw[1]) - 33'(yw[7]));
                e.eta_y = half_of(33'(xw[7]) - 33'(xw[1]));
                n_metric++;
            end
            e.cell_area = '0;
            if (e.area_valid) begin
                d1 = xw[8] - xw[4];
                d2 = yw[5] - yw[7];
                d3 = yw[8] - yw[4];
                d4 = xw[5] - xw[7];
                p = d1 * d2;
                q = d3 * d4;
                dd = p - q;
                sh = dd >>> 17;
                // saturate to the signed 32-bit range
                if (sh > $signed(67'h7FFF_FFFF))
                    e.cell_area = 32'h7FFF_FFFF;
                else if (sh < -$signed(67'h8000_0000))
                    e.cell_area = 32'h8000_0000;
                else
                    e.cell_area = sh[31:0];
                n_area++;
            end
            e.min_spacing = '0;
            if (e.spacing_valid) begin
                m = sq_dist(7, 4);
                t = sq_dist(5, 4); if (t < m) m = t;
                t = sq_dist(1, 4); if (t < m) m = t;
                t = sq_dist(3, 4); if (t < m) m = t;
                e.min_spacing = (m[65:64] != 0) ? 32'hFFFF_FFFF : root64(m[63:0]);
                n_spacing++;
            end

            col_cnt = c + 1;
            if (col_cnt >= GRID_COLS) begin
                col_cnt = 0;
                row_cnt = r + 1;
                if (row_cnt >= GRID_ROWS) row_cnt = 0;
            end
            pending_q.push_back(e);
            n_in++;
        endfunction

        function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, exp_v,
                         act_v);
                errors++;
            end
        endfunction

        function void check_result(t_metric_res a);
            t_metric_res e;
            n_out++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result at centre (%0d,%0d)", $time, a.center_row,
                         a.center_col);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            cmp_field("center_row", e.center_row, a.center_row);
            cmp_field("center_col", e.center_col, a.center_col);
            cmp_field("metric_valid", e.metric_valid, a.metric_valid);
            cmp_field("xi_x", e.xi_x, a.xi_x);
            cmp_field("xi_y", e.xi_y, a.xi_y);
            cmp_field("eta_x", e.eta_x, a.eta_x);
            cmp_field("eta_y", e.eta_y, a.eta_y);
            cmp_field("area_valid", e.area_valid, a.area_valid);
            cmp_field("cell_area", e.cell_area, a.cell_area);
            cmp_field("spacing_valid", e.spacing_valid, a.spacing_valid);
            cmp_field("min_spacing", e.min_spacing, a.min_spacing);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic quiet;
    int   idle_cycles = 0;

    gms_in_if  in_ch ();
    gms_out_if out_ch ();

    grid_metric_stencil u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    metric_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // push one grid point, holding it until the block takes the request
    task automatic send_point(logic signed [31:0] xv, logic signed [31:0] yv, logic fp);
        while (!quiet && $urandom_range(99) < 8) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.x_coord     <= xv;
        in_ch.y_coord     <= yv;
        in_ch.first_point <= fp;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_point(xv, yv, fp);
    endtask

    function automatic logic signed [31:0] pick_coord(int idx, int step);
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(0);
            3: return -32'sd1;
            4: return $urandom();
            default: return 32'(idx * step) + 32'($urandom_range(2047)) - 32'sd1024;
        endcase
    endfunction

    // one grid: well-formed coordinates with random jitter and extremes
    task automatic send_grid(int npts);
        int step_x, step_y;
        step_x = $urandom_range(1, 1 << 18);
        step_y = $urandom_range(1, 1 << 18);
        for (int i = 0; i < npts; i++)
            send_point(pick_coord(i % GRID_COLS, step_x), pick_coord(i / GRID_COLS, step_y),
                       i == 0);
    endtask

    // result side: check, then stall at random
    always @(posedge i_clk) begin
        t_metric_res a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a.center_row    = out_ch.center_row;
            a.center_col    = out_ch.center_col;
            a.metric_valid  = out_ch.metric_valid;
            a.xi_x          = out_ch.xi_x;
            a.xi_y          = out_ch.xi_y;
            a.eta_x         = out_ch.eta_x;
            a.eta_y         = out_ch.eta_y;
            a.area_valid    = out_ch.area_valid;
            a.cell_area     = out_ch.cell_area;
            a.spacing_valid = out_ch.spacing_valid;
            a.min_spacing   = out_ch.min_spacing;
            sb.check_result(a);
        end
        out_ch.ready <= quiet || ($urandom_range(99) >= 8);
    end

    // watchdog on cycles with no request moving either way
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", sb.pending_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] ext [5];
        int wait_cnt;
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h5555_AAAA};
        i_rst_n           = 1'b0;
        quiet             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.x_coord     = '0;
        in_ch.y_coord     = '0;
        in_ch.first_point = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, a mid-row restart
        for (int i = 0; i < 20; i++)
            send_point(ext[i % 5], ~ext[(i + 2) % 5], i == 0 || i == 12);

        // long grid reaching the interior rows, partly without idling
        quiet <= 1'b0;
        fork
            begin
                repeat (300) @(posedge i_clk);
                quiet <= 1'b1;
                repeat (200) @(posedge i_clk);
                quiet <= 1'b0;
            end
        join_none
        send_grid(800);
        // short grids with random restarts
        while (sb.n_in < 950) send_grid($urandom_range(5, 40));
        in_ch.valid <= 1'b0;

        wait_cnt = 0;
        while (sb.pending_q.size() != 0 && wait_cnt < 100 * WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d points, checked %0d results: %0d metric, %0d area, %0d spacing",
                 sb.n_in, sb.n_out, sb.n_metric, sb.n_area, sb.n_spacing);
        $display("%0d errors, %0d results never arrived", sb.errors, sb.pending_q.size());
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/gms_pkg.sv
rtl/gms_if.sv
rtl/gms_ctrl.sv
rtl/gms_dp.sv
rtl/grid_metric_stencil.sv
tb/sv/grid_metric_stencil_tb.sv
